// ===== sv/msd_pkg.sv =====
package msd_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned HoldWidth    = 16;
  localparam int unsigned StampWidth   = 32;
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned ClipWidth    = 16;
  localparam int unsigned ScreenWidth  = 15;
  localparam int unsigned NowWidth     = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_USE_ENGINE_PAUSE   = 3'd0,
    REG_ENGINE_READY       = 3'd1,
    REG_REQUIRE_FOREGROUND = 3'd2,
    REG_USE_CURSOR_VISIBLE = 3'd3,
    REG_USE_CURSOR_CLIP    = 3'd4,
    REG_OPEN_HOLD_MS       = 3'd5,
    REG_CLOSE_HOLD_MS      = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic                 use_engine_pause;
    logic                 engine_ready;
    logic                 require_foreground;
    logic                 use_cursor_visible;
    logic                 use_cursor_clip;
    logic [HoldWidth-1:0] open_hold_ms;
    logic [HoldWidth-1:0] close_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic                          quit_seen;
    logic                          engine_pause_bit;
    logic                          is_foreground;
    logic                          cursor_shown;
    logic                          clip_valid;
    logic signed [ClipWidth-1:0]   clip_width;
    logic signed [ClipWidth-1:0]   clip_height;
    logic [ScreenWidth-1:0]        screen_width;
    logic [ScreenWidth-1:0]        screen_height;
    logic [NowWidth-1:0]           now_ms;
  } sample_t;

  typedef struct packed {
    logic raw;
    logic exact;
  } raw_info_t;

  typedef struct packed {
    logic                  menu_is_open;
    logic                  opened_now;
    logic                  closed_now;
    logic                  raw_indication;
    logic [CountWidth-1:0] session_count;
    logic [StampWidth-1:0] open_stamp;
    logic [StampWidth-1:0] close_stamp;
    logic                  halted;
  } result_t;

endpackage

// ===== sv/msd_cfg_regs.sv =====
module msd_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [msd_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [msd_pkg::CfgDataWidth-1:0]     cfg_data_i,
  output msd_pkg::cfg_t                        cfg_o
);
  import msd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_USE_ENGINE_PAUSE:   cfg_d.use_engine_pause   = cfg_data_i[0];
        REG_ENGINE_READY:       cfg_d.engine_ready       = cfg_data_i[0];
        REG_REQUIRE_FOREGROUND: cfg_d.require_foreground = cfg_data_i[0];
        REG_USE_CURSOR_VISIBLE: cfg_d.use_cursor_visible = cfg_data_i[0];
        REG_USE_CURSOR_CLIP:    cfg_d.use_cursor_clip    = cfg_data_i[0];
        REG_OPEN_HOLD_MS:       cfg_d.open_hold_ms       = cfg_data_i[HoldWidth-1:0];
        REG_CLOSE_HOLD_MS:      cfg_d.close_hold_ms      = cfg_data_i[HoldWidth-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_engine_pause   <= 1'b1;
      cfg_q.engine_ready       <= 1'b0;
      cfg_q.require_foreground <= 1'b1;
      cfg_q.use_cursor_visible <= 1'b1;
      cfg_q.use_cursor_clip    <= 1'b0;
      cfg_q.open_hold_ms       <= '0;
      cfg_q.close_hold_ms      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/msd_raw_sel.sv =====
module msd_raw_sel #(
  parameter int unsigned CLIP_MARGIN = 32
) (
  input  msd_pkg::cfg_t      cfg_i,
  input  msd_pkg::sample_t   sample_i,
  output msd_pkg::raw_info_t info_o
);
  import msd_pkg::*;

  localparam int unsigned CmpWidth = ScreenWidth + 2;

  logic signed [CmpWidth-1:0] w_s, h_s, sw_s, sh_s, sw_m, sh_m;
  logic                       clipped;
  logic                       exact;
  logic                       heur;

  always_comb begin
    w_s  = CmpWidth'(sample_i.clip_width);
    h_s  = CmpWidth'(sample_i.clip_height);
    sw_s = $signed({2'b00, sample_i.screen_width});
    sh_s = $signed({2'b00, sample_i.screen_height});
    sw_m = sw_s - $signed(CmpWidth'(CLIP_MARGIN));
    sh_m = sh_s - $signed(CmpWidth'(CLIP_MARGIN));
    clipped = sample_i.clip_valid && (w_s < sw_s) && (h_s < sh_s) &&
              ((w_s < sw_m) || (h_s < sh_m));

    exact = cfg_i.use_engine_pause && cfg_i.engine_ready;
    heur  = (cfg_i.use_cursor_visible && sample_i.cursor_shown) ||
            (cfg_i.use_cursor_clip && clipped);

    info_o.exact = exact;
    if (exact) begin
      info_o.raw = sample_i.engine_pause_bit;
    end else if (cfg_i.require_foreground && !sample_i.is_foreground) begin
      info_o.raw = 1'b0;
    end else begin
      info_o.raw = heur;
    end
  end

endmodule

// ===== sv/msd_debounce.sv =====
module msd_debounce #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  msd_pkg::cfg_t      cfg_i,
  input  msd_pkg::sample_t   sample_i,
  input  msd_pkg::raw_info_t info_i,
  output msd_pkg::result_t   result_o
);
  import msd_pkg::*;

  logic                        started_q, started_d;
  logic                        raw_prev_q, raw_prev_d;
  logic [TIME_WIDTH-1:0]       chg_time_q, chg_time_d;
  logic                        open_q, open_d;
  logic [CountWidth-1:0]       count_q, count_d;
  logic [TIME_WIDTH-1:0]       open_time_q, open_time_d;
  logic [TIME_WIDTH-1:0]       close_time_q, close_time_d;
  logic                        halt_q, halt_d;
  result_t                     result_q, result_d;

  logic [TIME_WIDTH+NowWidth-1:0]   now_ext;
  logic [TIME_WIDTH-1:0]            now_t;
  logic [TIME_WIDTH-1:0]            stable;
  logic [TIME_WIDTH-1:0]            open_hold, close_hold;
  logic                             prev_eff;
  logic [StampWidth+TIME_WIDTH-1:0] open_ext, close_ext;

  always_comb begin
    now_ext = {{TIME_WIDTH{1'b0}}, sample_i.now_ms};
    now_t   = now_ext[TIME_WIDTH-1:0];

    started_d    = started_q;
    raw_prev_d   = raw_prev_q;
    chg_time_d   = chg_time_q;
    open_d       = open_q;
    count_d      = count_q;
    open_time_d  = open_time_q;
    close_time_d = close_time_q;
    halt_d       = halt_q;

    prev_eff   = started_q ? raw_prev_q : 1'b0;
    open_hold  = info_i.exact ? '0 : TIME_WIDTH'(cfg_i.open_hold_ms);
    close_hold = info_i.exact ? '0 : TIME_WIDTH'(cfg_i.close_hold_ms);
    stable     = '0;

    result_d                = '0;

    if (halt_q || sample_i.quit_seen) begin
      halt_d = 1'b1;
      open_d = 1'b0;
    end else begin
      started_d  = 1'b1;
      raw_prev_d = info_i.raw;
      if (!started_q || (info_i.raw != prev_eff)) begin
        chg_time_d = now_t;
      end
      stable = now_t - chg_time_d;
      if (!open_q && info_i.raw && (stable >= open_hold)) begin
        open_time_d         = now_t;
        count_d             = count_q + CountWidth'(1);
        open_d              = 1'b1;
        result_d.opened_now = 1'b1;
      end else if (open_q && !info_i.raw && (stable >= close_hold)) begin
        close_time_d        = now_t;
        open_d              = 1'b0;
        result_d.closed_now = 1'b1;
      end
      result_d.raw_indication = info_i.raw;
    end

    open_ext  = {{StampWidth{1'b0}}, open_time_d};
    close_ext = {{StampWidth{1'b0}}, close_time_d};
    result_d.menu_is_open  = open_d;
    result_d.session_count = count_d;
    result_d.open_stamp    = open_ext[StampWidth-1:0];
    result_d.close_stamp   = close_ext[StampWidth-1:0];
    result_d.halted        = halt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      raw_prev_q   <= 1'b0;
      chg_time_q   <= '0;
      open_q       <= 1'b0;
      count_q      <= '0;
      open_time_q  <= '0;
      close_time_q <= '0;
      halt_q       <= 1'b0;
    end else if (step_i) begin
      started_q    <= started_d;
      raw_prev_q   <= raw_prev_d;
      chg_time_q   <= chg_time_d;
      open_q       <= open_d;
      count_q      <= count_d;
      open_time_q  <= open_time_d;
      close_time_q <= close_time_d;
      halt_q       <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ===== sv/menu_state_debouncer_core.sv =====
// A word accepted is held in the input register, then passes through the state update
// into the result register. Throughput: one word per cycle while the output is taken;
// the single-pass state update and the result register after it set that figure. A
// waiting result blocks input only once the input register also holds a word.
// Reset clears the configuration to its defaults, the debounce state, counters,
// stamps and the halt latch, and empties both pipeline stages.
module menu_state_debouncer_core #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned CLIP_MARGIN = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,

  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [msd_pkg::CfgIdxWidth-1:0]            cfg_index_i,
  input  logic [msd_pkg::CfgDataWidth-1:0]           cfg_data_i,

  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic                                       quit_seen_i,
  input  logic                                       engine_pause_bit_i,
  input  logic                                       is_foreground_i,
  input  logic                                       cursor_shown_i,
  input  logic                                       clip_valid_i,
  input  logic signed [msd_pkg::ClipWidth-1:0]       clip_width_i,
  input  logic signed [msd_pkg::ClipWidth-1:0]       clip_height_i,
  input  logic [msd_pkg::ScreenWidth-1:0]            screen_width_i,
  input  logic [msd_pkg::ScreenWidth-1:0]            screen_height_i,
  input  logic [msd_pkg::NowWidth-1:0]               now_ms_i,

  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic                                       menu_is_open_o,
  output logic                                       opened_now_o,
  output logic                                       closed_now_o,
  output logic                                       raw_indication_o,
  output logic [msd_pkg::CountWidth-1:0]             session_count_o,
  output logic [msd_pkg::StampWidth-1:0]             open_stamp_o,
  output logic [msd_pkg::StampWidth-1:0]             close_stamp_o,
  output logic                                       halted_o
);
  import msd_pkg::*;

  cfg_t      cfg;
  sample_t   s1_q;
  logic      s1_valid_q, s1_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      step;
  logic      in_take;
  raw_info_t info;
  result_t   result;

  assign cfg_ready_o = 1'b1;

  msd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The second stage moves a word forward whenever the result register is
  // empty or its word is being taken this cycle.
  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d  = in_take || (s1_valid_q && !step);
    out_valid_d = step || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.quit_seen        <= quit_seen_i;
      s1_q.engine_pause_bit <= engine_pause_bit_i;
      s1_q.is_foreground    <= is_foreground_i;
      s1_q.cursor_shown     <= cursor_shown_i;
      s1_q.clip_valid       <= clip_valid_i;
      s1_q.clip_width       <= clip_width_i;
      s1_q.clip_height      <= clip_height_i;
      s1_q.screen_width     <= screen_width_i;
      s1_q.screen_height    <= screen_height_i;
      s1_q.now_ms           <= now_ms_i;
    end
  end

  msd_raw_sel #(
    .CLIP_MARGIN (CLIP_MARGIN)
  ) u_raw (
    .cfg_i    (cfg),
    .sample_i (s1_q),
    .info_o   (info)
  );

  msd_debounce #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_deb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg),
    .sample_i (s1_q),
    .info_i   (info),
    .result_o (result)
  );

  assign out_valid_o      = out_valid_q;
  assign menu_is_open_o   = result.menu_is_open;
  assign opened_now_o     = result.opened_now;
  assign closed_now_o     = result.closed_now;
  assign raw_indication_o = result.raw_indication;
  assign session_count_o  = result.session_count;
  assign open_stamp_o     = result.open_stamp;
  assign close_stamp_o    = result.close_stamp;
  assign halted_o         = result.halted;

endmodule
